>>> hw/rtl/ibi_median_heart_rate_estimate_top_macros.svh
// ----------------------------------------------------------------------------
// ibi_median_heart_rate_estimate_top_macros.svh
// assertion helpers for the heart rate estimator
// ----------------------------------------------------------------------------
`ifndef IBI_MEDIAN_HEART_RATE_ESTIMATE_TOP_MACROS_SVH
`define IBI_MEDIAN_HEART_RATE_ESTIMATE_TOP_MACROS_SVH

// clocked check, off during reset
`define IBIMHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on the next clock
`define IBIMHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ibimhr_pkg.sv
// ----------------------------------------------------------------------------
// ibimhr_pkg
// shared types and constants of the heart rate estimator
// ----------------------------------------------------------------------------
`default_nettype none

package ibimhr_pkg;

  // command codes
  localparam logic [1:0] CMD_APPEND   = 2'd0;
  localparam logic [1:0] CMD_REPLACE  = 2'd1;
  localparam logic [1:0] CMD_ESTIMATE = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_WINDOW  = 3'd0;
  localparam logic [2:0] REG_MIN_IBI = 3'd1;
  localparam logic [2:0] REG_MAX_IBI = 3'd2;
  localparam logic [2:0] REG_TOL     = 3'd3;
  localparam logic [2:0] REG_MIN_BT  = 3'd4;
  localparam logic [2:0] REG_MIN_Q   = 3'd5;

  // register reset values
  localparam logic [15:0] RST_WINDOW  = 16'd10000;
  localparam logic [11:0] RST_MIN_IBI = 12'd286;
  localparam logic [11:0] RST_MAX_IBI = 12'd2100;
  localparam logic [7:0]  RST_TOL     = 8'd64;
  localparam logic [6:0]  RST_MIN_BT  = 7'd4;
  localparam logic [8:0]  RST_MIN_Q   = 9'd179;

  // arithmetic constants
  localparam logic [33:0] LOOKAHEAD_MS = 34'd1000;
  localparam logic [31:0] RATE_X2      = 32'd1920000;  // 2 * 60000 * 16
  localparam logic [31:0] RATE_X4      = 32'd3840000;
  localparam logic [16:0] RECENT_FLOOR = 17'd20000;
  localparam logic [16:0] RECENT_MUL   = 17'd11;
  localparam logic signed [36:0] RECENT_SCALE = 37'sd10;
  localparam logic [15:0] BPM_MAX      = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_SEL_RD,
    ST_SEL_CAND,
    ST_CNT_RD,
    ST_CNT,
    ST_LIM,
    ST_AVG_RD,
    ST_AVG,
    ST_CHK,
    ST_DIVQ,
    ST_BPM,
    ST_DIVR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // interval inside [lo, hi]
  function automatic logic ibi_in_range(logic signed [32:0] v, logic [11:0] lo,
                                        logic [11:0] hi);
    return (v >= $signed({21'd0, lo})) && (v <= $signed({21'd0, hi}));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ibimhr_div.sv
// ----------------------------------------------------------------------------
// ibimhr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ibimhr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  ibimhr_pkg::div_ctl_t ctl,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output ibimhr_pkg::div_sts_t sts,
  output logic [31:0]          quo
);

  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic        fits;

  // trial subtract
  assign shifted = {rem, q[31]};
  assign fits    = shifted >= {1'b0, dv};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q   <= num;
      dv  <= den;
      rem <= 32'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= 32'(shifted - {1'b0, dv});
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo      = q;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

`default_nettype wire

>>> hw/rtl/ibi_median_heart_rate_estimate_top.sv
// ----------------------------------------------------------------------------
// ibi_median_heart_rate_estimate_top
// heart rate from a ring of beat times, median filtered intervals
// ----------------------------------------------------------------------------
// Usage: beat times and commands arrive on the in channel (cmd, time_ms).
// Append, replace and clear give no word on the out channel. An estimate
// walks the ring, then selects the median interval with a counting pass
// that counts smaller and equal intervals for each candidate, then averages
// agreeing intervals and runs a quality division and, unless the rate
// denominator is zero, a rate division on one shared divider. in_ready is
// low while an estimate runs.
// The result word sits in an output register; the next command is taken
// while it waits, and a finished estimate holds until out_ready frees it.
// Registers are written on the cfg channel while the block is idle.
// Reset empties the ring and loads the register defaults; the beat memory
// itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ibi_median_heart_rate_estimate_top #(
  parameter int BEAT_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        has_rate,
  output logic        valid_res,
  output logic [15:0] bpm_q4,
  output logic [8:0]  quality_q8,
  output logic [6:0]  beat_count,
  output logic [5:0]  ibi_count,
  output logic        has_last_beat,
  output logic [31:0] last_beat_ms
);

  localparam int AW   = $clog2(BEAT_DEPTH);
  localparam int CW   = $clog2(BEAT_DEPTH + 1);
  localparam int SUMW = 13 + CW;
  localparam logic [AW-1:0] LAST_IDX  = AW'(BEAT_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(BEAT_DEPTH);

  ibimhr_pkg::state_t state, state_next;

  // configuration
  logic [15:0] window_ms;
  logic [11:0] min_ibi_ms;
  logic [11:0] max_ibi_ms;
  logic [7:0]  tolerance_q8;
  logic [6:0]  min_beats;
  logic [8:0]  min_quality_q8;

  // ring
  logic [31:0] beat_mem [BEAT_DEPTH];
  logic [31:0] beat_q;
  logic [CW-1:0] fill;
  logic [AW-1:0] head;
  logic [AW-1:0] head_prev;
  logic [CW:0]   start_sum;
  logic [AW-1:0] start_idx;
  logic          bw_en;
  logic [AW-1:0] bw_addr;

  // interval memory
  logic signed [32:0] ibi_mem [BEAT_DEPTH];
  logic signed [32:0] ibi_q;
  logic [AW-1:0]      ibi_raddr;

  // estimate working registers
  logic [31:0]   now_ms;
  logic [31:0]   prev_ms;
  logic          has_prev;
  logic [AW-1:0] ptr;
  logic [CW-1:0] idx;
  logic [CW-1:0] beats;
  logic [CW-1:0] nall;
  logic [CW-1:0] nin;
  logic [CW-1:0] j;
  logic [CW-1:0] m;
  logic [CW-1:0] lt;
  logic [CW-1:0] le;
  logic [11:0]   cand;
  logic          found_lo;
  logic          found_hi;
  logic [11:0]   med_lo;
  logic [11:0]   med_hi;
  logic [12:0]   med2;
  logic [12:0]   lim_th;
  logic [CW-1:0] avg_idx;
  logic [SUMW-1:0] sum;
  logic [CW-1:0] agree_cnt;
  logic          ok_all;
  logic [8:0]    qual;
  logic [15:0]   bpm;

  // combinational helpers
  logic               accept;
  logic               est_accept;
  logic               med_found;
  logic               in_win;
  logic signed [32:0] scan_ibi;
  logic               q_in_range;
  logic [CW-1:0]      k1;
  logic [CW-1:0]      k2;
  logic               hit1;
  logic               hit2;
  logic               sel_done;
  logic [12:0]        med_sum;
  logic [20:0]        lim_full;
  logic signed [34:0] dev;
  logic [34:0]        dev_abs;
  logic               agree;
  logic               ok_q;
  logic               ok_m;
  logic               ok_r;
  logic               beats_ok;
  logic signed [32:0] age;
  logic signed [36:0] age10;
  logic [16:0]        recent_raw;
  logic [16:0]        recent_lim;
  logic               den_zero;
  logic               out_free;

  // divider
  ibimhr_pkg::div_ctl_t div_ctl;
  ibimhr_pkg::div_sts_t div_sts;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic [31:0] div_quo;

  ibimhr_div u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .num (div_num),
    .den (div_den),
    .sts (div_sts),
    .quo (div_quo)
  );

  assign accept     = in_valid && in_ready;
  assign est_accept = accept && (cmd == ibimhr_pkg::CMD_ESTIMATE);
  assign med_found  = found_lo && found_hi;
  assign out_free   = !out_valid || out_ready;

  // ring pointers
  assign head_prev = (head == '0) ? LAST_IDX : head - AW'(1);
  assign start_sum = (CW+1)'(head) + (CW+1)'(BEAT_DEPTH) - (CW+1)'(fill);
  assign start_idx = (start_sum >= (CW+1)'(BEAT_DEPTH))
                   ? AW'(start_sum - (CW+1)'(BEAT_DEPTH)) : AW'(start_sum);

  // window test and interval of the current beat
  assign in_win = (({2'b0, beat_q} + {18'd0, window_ms}) >= {2'b0, now_ms}) &&
                  ({2'b0, beat_q} <= ({2'b0, now_ms} + ibimhr_pkg::LOOKAHEAD_MS));
  assign scan_ibi = $signed({1'b0, beat_q}) - $signed({1'b0, prev_ms});
  assign q_in_range = ibimhr_pkg::ibi_in_range(ibi_q, min_ibi_ms, max_ibi_ms);

  // median selection ranks
  assign k1       = (nin - CW'(1)) >> 1;
  assign k2       = nin >> 1;
  assign hit1     = (lt <= k1) && (k1 < le);
  assign hit2     = (lt <= k2) && (k2 < le);
  assign sel_done = (found_lo || hit1) && (found_hi || hit2);

  // tolerance band
  assign med_sum  = {1'b0, med_lo} + {1'b0, med_hi};
  assign lim_full = 21'(tolerance_q8) * 21'(med_sum);
  assign dev      = 35'(ibi_q) * 35'sd2 - $signed({22'd0, med2});
  assign dev_abs  = dev[34] ? 35'(-dev) : 35'(dev);
  assign agree    = dev_abs <= {22'd0, lim_th};

  // validity checks
  assign ok_q = ((9+CW)'(agree_cnt) << 8) >= ((9+CW)'(min_quality_q8) * (9+CW)'(nall));
  always_comb begin
    if (agree_cnt != '0) begin
      ok_m = (sum >= SUMW'(SUMW'(min_ibi_ms) * SUMW'(agree_cnt))) &&
             (sum <= SUMW'(SUMW'(max_ibi_ms) * SUMW'(agree_cnt)));
    end else begin
      ok_m = (med2 >= {min_ibi_ms, 1'b0}) && (med2 <= {max_ibi_ms, 1'b0});
    end
  end
  assign age        = $signed({1'b0, now_ms}) - $signed({1'b0, prev_ms});
  assign age10      = 37'(age) * ibimhr_pkg::RECENT_SCALE;
  assign recent_raw = 17'(med2) * ibimhr_pkg::RECENT_MUL;
  assign recent_lim = (recent_raw < ibimhr_pkg::RECENT_FLOOR)
                    ? ibimhr_pkg::RECENT_FLOOR : recent_raw;
  assign ok_r       = age10 <= $signed({20'd0, recent_lim});
  assign beats_ok   = 10'(beats) >= 10'(min_beats);
  assign den_zero   = (agree_cnt != '0) ? (sum == '0) : (med2 == '0);

  // configuration registers
  assign cfg_ready = (state == ibimhr_pkg::ST_IDLE) && !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms      <= ibimhr_pkg::RST_WINDOW;
      min_ibi_ms     <= ibimhr_pkg::RST_MIN_IBI;
      max_ibi_ms     <= ibimhr_pkg::RST_MAX_IBI;
      tolerance_q8   <= ibimhr_pkg::RST_TOL;
      min_beats      <= ibimhr_pkg::RST_MIN_BT;
      min_quality_q8 <= ibimhr_pkg::RST_MIN_Q;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ibimhr_pkg::REG_WINDOW:  window_ms      <= cfg_data;
        ibimhr_pkg::REG_MIN_IBI: min_ibi_ms     <= cfg_data[11:0];
        ibimhr_pkg::REG_MAX_IBI: max_ibi_ms     <= cfg_data[11:0];
        ibimhr_pkg::REG_TOL:     tolerance_q8   <= cfg_data[7:0];
        ibimhr_pkg::REG_MIN_BT:  min_beats      <= cfg_data[6:0];
        ibimhr_pkg::REG_MIN_Q:   min_quality_q8 <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ibimhr_pkg::ST_IDLE:
        if (est_accept) state_next = ibimhr_pkg::ST_SCAN_RD;
      ibimhr_pkg::ST_SCAN_RD:
        if (idx == fill) begin
          state_next = (nin == '0) ? ibimhr_pkg::ST_DONE : ibimhr_pkg::ST_SEL_RD;
        end else begin
          state_next = ibimhr_pkg::ST_SCAN;
        end
      ibimhr_pkg::ST_SCAN:     state_next = ibimhr_pkg::ST_SCAN_RD;
      ibimhr_pkg::ST_SEL_RD:   state_next = ibimhr_pkg::ST_SEL_CAND;
      ibimhr_pkg::ST_SEL_CAND:
        state_next = q_in_range ? ibimhr_pkg::ST_CNT_RD : ibimhr_pkg::ST_SEL_RD;
      ibimhr_pkg::ST_CNT_RD:
        if (m == nall) begin
          state_next = sel_done ? ibimhr_pkg::ST_LIM : ibimhr_pkg::ST_SEL_RD;
        end else begin
          state_next = ibimhr_pkg::ST_CNT;
        end
      ibimhr_pkg::ST_CNT:      state_next = ibimhr_pkg::ST_CNT_RD;
      ibimhr_pkg::ST_LIM:      state_next = ibimhr_pkg::ST_AVG_RD;
      ibimhr_pkg::ST_AVG_RD:
        state_next = (avg_idx == nall) ? ibimhr_pkg::ST_CHK : ibimhr_pkg::ST_AVG;
      ibimhr_pkg::ST_AVG:      state_next = ibimhr_pkg::ST_AVG_RD;
      ibimhr_pkg::ST_CHK:      state_next = ibimhr_pkg::ST_DIVQ;
      ibimhr_pkg::ST_DIVQ:
        if (div_sts.done) state_next = ibimhr_pkg::ST_BPM;
      ibimhr_pkg::ST_BPM:
        state_next = den_zero ? ibimhr_pkg::ST_DONE : ibimhr_pkg::ST_DIVR;
      ibimhr_pkg::ST_DIVR:
        if (div_sts.done) state_next = ibimhr_pkg::ST_DONE;
      ibimhr_pkg::ST_DONE:
        if (out_free) state_next = ibimhr_pkg::ST_IDLE;
      default: state_next = ibimhr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibimhr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    in_ready      = (state == ibimhr_pkg::ST_IDLE) && !rst;
    div_ctl.start = (state == ibimhr_pkg::ST_CHK) ||
                    ((state == ibimhr_pkg::ST_BPM) && !den_zero);
    bw_en   = accept && ((cmd == ibimhr_pkg::CMD_APPEND) ||
                         ((cmd == ibimhr_pkg::CMD_REPLACE) && (fill != '0)));
    bw_addr = (cmd == ibimhr_pkg::CMD_APPEND) ? head : head_prev;
    case (state)
      ibimhr_pkg::ST_SEL_RD: ibi_raddr = j[AW-1:0];
      ibimhr_pkg::ST_CNT_RD: ibi_raddr = m[AW-1:0];
      default:               ibi_raddr = avg_idx[AW-1:0];
    endcase
    if (state == ibimhr_pkg::ST_CHK) begin
      div_num = (32'(agree_cnt) << 9) + 32'(nall);
      div_den = 32'(nall) << 1;
    end else if (agree_cnt != '0) begin
      div_num = ibimhr_pkg::RATE_X2 * 32'(agree_cnt) + 32'(sum);
      div_den = 32'(sum) << 1;
    end else begin
      div_num = ibimhr_pkg::RATE_X4 + 32'(med2);
      div_den = 32'(med2) << 1;
    end
  end

  // beat memory
  always_ff @(posedge clk) begin
    if (bw_en) beat_mem[bw_addr] <= time_ms;
    beat_q <= beat_mem[ptr];
  end

  // interval memory
  always_ff @(posedge clk) begin
    if (state == ibimhr_pkg::ST_SCAN && in_win && has_prev) begin
      ibi_mem[nall[AW-1:0]] <= scan_ibi;
    end
    ibi_q <= ibi_mem[ibi_raddr];
  end

  // ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      head <= '0;
    end else if (accept) begin
      case (cmd)
        ibimhr_pkg::CMD_APPEND: begin
          head <= (head == LAST_IDX) ? '0 : head + AW'(1);
          if (fill < DEPTH_CNT) fill <= fill + CW'(1);
        end
        ibimhr_pkg::CMD_CLEAR: begin
          fill <= '0;
          head <= '0;
        end
        default: ;
      endcase
    end
  end

  // estimate datapath
  always_ff @(posedge clk) begin
    case (state)
      ibimhr_pkg::ST_IDLE: begin
        if (est_accept) begin
          now_ms    <= time_ms;
          ptr       <= start_idx;
          idx       <= '0;
          beats     <= '0;
          nall      <= '0;
          nin       <= '0;
          has_prev  <= 1'b0;
          j         <= '0;
          found_lo  <= 1'b0;
          found_hi  <= 1'b0;
          avg_idx   <= '0;
          sum       <= '0;
          agree_cnt <= '0;
        end
      end
      ibimhr_pkg::ST_SCAN: begin
        ptr <= (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
        idx <= idx + CW'(1);
        if (in_win) begin
          beats <= beats + CW'(1);
          if (has_prev) begin
            nall <= nall + CW'(1);
            if (ibimhr_pkg::ibi_in_range(scan_ibi, min_ibi_ms, max_ibi_ms)) begin
              nin <= nin + CW'(1);
            end
          end
          prev_ms  <= beat_q;
          has_prev <= 1'b1;
        end
      end
      ibimhr_pkg::ST_SEL_CAND: begin
        if (q_in_range) begin
          cand <= ibi_q[11:0];
          m    <= '0;
          lt   <= '0;
          le   <= '0;
        end else begin
          j <= j + CW'(1);
        end
      end
      ibimhr_pkg::ST_CNT_RD: begin
        if (m == nall) begin
          if (!found_lo && hit1) begin
            med_lo   <= cand;
            found_lo <= 1'b1;
          end
          if (!found_hi && hit2) begin
            med_hi   <= cand;
            found_hi <= 1'b1;
          end
          j <= j + CW'(1);
        end
      end
      ibimhr_pkg::ST_CNT: begin
        if (q_in_range) begin
          if (ibi_q < $signed({21'd0, cand}))  lt <= lt + CW'(1);
          if (ibi_q <= $signed({21'd0, cand})) le <= le + CW'(1);
        end
        m <= m + CW'(1);
      end
      ibimhr_pkg::ST_LIM: begin
        med2   <= med_sum;
        lim_th <= lim_full[20:8];
      end
      ibimhr_pkg::ST_AVG: begin
        if (agree) begin
          sum       <= sum + SUMW'(ibi_q[12:0]);
          agree_cnt <= agree_cnt + CW'(1);
        end
        avg_idx <= avg_idx + CW'(1);
      end
      ibimhr_pkg::ST_CHK: begin
        ok_all <= beats_ok && ok_q && ok_m && ok_r;
      end
      ibimhr_pkg::ST_DIVQ: begin
        if (div_sts.done) qual <= div_quo[8:0];
      end
      ibimhr_pkg::ST_BPM: begin
        if (den_zero) bpm <= ibimhr_pkg::BPM_MAX;
      end
      ibimhr_pkg::ST_DIVR: begin
        if (div_sts.done) begin
          bpm <= (div_quo > 32'(ibimhr_pkg::BPM_MAX)) ? ibimhr_pkg::BPM_MAX : div_quo[15:0];
        end
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ibimhr_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ibimhr_pkg::ST_DONE && out_free) begin
      has_rate      <= (nin != '0);
      valid_res     <= (nin != '0) && ok_all;
      bpm_q4        <= (nin != '0) ? bpm : 16'd0;
      quality_q8    <= (nin != '0) ? qual : 9'd0;
      beat_count    <= ((CW+8)'(beats) > (CW+8)'(127)) ? 7'd127 : 7'(beats);
      ibi_count     <= ((CW+8)'(nall) > (CW+8)'(63)) ? 6'd63 : 6'(nall);
      has_last_beat <= has_prev;
      last_beat_ms  <= has_prev ? prev_ms : 32'd0;
    end
  end

  // checks
  `include "ibi_median_heart_rate_estimate_top_macros.svh"

  `IBIMHR_ASSERT(a_fill_bound, fill <= DEPTH_CNT, "ring fill beyond depth")
  `IBIMHR_ASSERT_NEXT(a_est_busy, est_accept, !in_ready, "estimate did not block input")
  `IBIMHR_ASSERT(a_median_found, state != ibimhr_pkg::ST_LIM || med_found, "median not found")

endmodule

`default_nettype wire
